// File: sv/bfth_pkg.sv
// ----------------------------------------------------------------------------
// bfth_pkg
// Shared types, constants and controller/datapath command set for the
// two-hash bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfth_pkg;

    localparam int MAX_WORDS = 1024;
    localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int NW        = $clog2(MAX_WORDS + 1);

    // XXH32 primes
    localparam logic [31:0] PR1 = 32'd2654435761;
    localparam logic [31:0] PR2 = 32'd2246822519;
    localparam logic [31:0] PR3 = 32'd3266489917;
    localparam logic [31:0] PR4 = 32'd668265263;
    localparam logic [31:0] PR5 = 32'd374761393;

    // register indexes
    localparam logic [1:0] CFG_SEED_ONE   = 2'd0;
    localparam logic [1:0] CFG_SEED_TWO   = 2'd1;
    localparam logic [1:0] CFG_WORD_MODE  = 2'd2;
    localparam logic [1:0] CFG_WORD_COUNT = 2'd3;

    localparam logic [1:0] MODE_W8      = 2'd0;
    localparam logic [1:0] MODE_W16     = 2'd1;
    localparam logic [1:0] MODE_W32     = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] key_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic hit;
        logic was_query;
    } out_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISP,
        S_R_MUL, S_R_ADD, S_R_LANE,
        S_F_INIT, S_F_LEN, S_F_CHK,
        S_W_MUL, S_W_ADD, S_W_MUL2,
        S_B_MUL, S_B_ADD, S_B_MUL2,
        S_X1, S_X2, S_X3, S_X4, S_X5, S_F_SAVE,
        S_M_START, S_M_STEP, S_M_SAVE,
        S_RD, S_CHK, S_RES
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_BYTE,
        DP_RND_MUL, DP_RND_ADD, DP_RND_LANE,
        DP_FIN_INIT, DP_FIN_LEN,
        DP_W_MUL, DP_W_ADD, DP_W_MUL2,
        DP_B_MUL, DP_B_ADD, DP_B_MUL2,
        DP_X15, DP_XM2, DP_X13, DP_XM3, DP_X16,
        DP_SAVE, DP_MOD_START, DP_MOD_STEP, DP_MOD_SAVE,
        DP_RD, DP_CHK, DP_RES
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       hsel;   // which hash: 0 = h1, 1 = h2
        logic [2:0] idx;    // lane for stripe rounds
        logic [3:0] pos;    // stripe buffer position
    } ctl_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       stripe_full;
        logic       last;
        logic [3:0] fill;
        logic       mode_ok;
        logic       out_full;
    } ctl_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

`default_nettype wire

// File: sv/bloom_filter_two_hash_core.sv
// ----------------------------------------------------------------------------
// bloom_filter_two_hash_core
// Bloom filter, two XXH32 hashes over one byte-serial key, 1024 x 32 store.
// ----------------------------------------------------------------------------
// Keys arrive one byte per request with a last marker; cmd on the last byte
// picks insert or query. A byte is taken in the idle state and dispatched
// before the next is taken; a byte that completes a 16-byte stripe adds
// eight lane rounds of three steps on the one shared 32x32 multiplier.
// The last byte then runs hash finalisation for both hashes on that
// multiplier, the one-bit-per-cycle remainder unit and a store read and
// check for each hash, and the load of the result register; with mode 3
// the remainder and store steps are skipped. The block takes one key at a
// time. After reset the filter store is swept to zero, one word per cycle,
// during which no request is taken; configuration writes are taken at any
// time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_two_hash_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // key byte requests
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bfth_pkg::in_t   s_data,
    // results
    output logic                 m_valid,
    input  wire logic            m_ready,
    output bfth_pkg::out_t       m_data,
    // register writes
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [31:0]     cfg_data
);
    import bfth_pkg::*;

    ctl_cmd_t dp_cmd;
    ctl_sts_t dp_sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    bfth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    bfth_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    no_take_while_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_byte) |=> !s_ready)
        else $error("request taken before previous key finished");

endmodule

`default_nettype wire

// File: sv/bfth_ram.sv
// ----------------------------------------------------------------------------
// bfth_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AWID = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AWID-1:0]  addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: sv/bfth_ctrl.sv
// ----------------------------------------------------------------------------
// bfth_ctrl
// Sequencer: byte intake, stripe rounds, finalisation, remainder and store
// access, one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfth_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bfth_pkg::ctl_sts_t  sts,
    output bfth_pkg::ctl_cmd_t       cmd
);
    import bfth_pkg::*;

    state_t     state_reg, state_next;
    logic       hs_reg, hs_next;
    logic [2:0] k_reg, k_next;
    logic [3:0] pos_reg, pos_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] pos_w;

    assign pos_w = {1'b0, pos_reg} + 5'd4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            hs_reg    <= 1'b0;
            k_reg     <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            hs_reg    <= hs_next;
            k_reg     <= k_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        hs_next    = hs_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:  if (s_valid) state_next = S_DISP;
            S_DISP: begin
                if (sts.stripe_full) begin
                    state_next = S_R_MUL;
                    k_next     = '0;
                end else if (sts.last) begin
                    state_next = S_F_INIT;
                    hs_next    = 1'b0;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_R_MUL: state_next = S_R_ADD;
            S_R_ADD: state_next = S_R_LANE;
            S_R_LANE: begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7) begin
                    if (sts.last) begin
                        state_next = S_F_INIT;
                        hs_next    = 1'b0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_R_MUL;
                end
            end
            S_F_INIT: begin
                state_next = S_F_LEN;
                pos_next   = '0;
            end
            S_F_LEN: state_next = S_F_CHK;
            S_F_CHK: begin
                if (pos_w <= {1'b0, sts.fill})  state_next = S_W_MUL;
                else if (pos_reg < sts.fill)   state_next = S_B_MUL;
                else                           state_next = S_X1;
            end
            S_W_MUL:  state_next = S_W_ADD;
            S_W_ADD:  state_next = S_W_MUL2;
            S_W_MUL2: begin
                state_next = S_F_CHK;
                pos_next   = pos_reg + 4'd4;
            end
            S_B_MUL:  state_next = S_B_ADD;
            S_B_ADD:  state_next = S_B_MUL2;
            S_B_MUL2: begin
                state_next = S_F_CHK;
                pos_next   = pos_reg + 4'd1;
            end
            S_X1: state_next = S_X2;
            S_X2: state_next = S_X3;
            S_X3: state_next = S_X4;
            S_X4: state_next = S_X5;
            S_X5: state_next = S_F_SAVE;
            S_F_SAVE: begin
                if (!hs_reg) begin
                    hs_next    = 1'b1;
                    state_next = S_F_INIT;
                end else if (sts.mode_ok) begin
                    hs_next    = 1'b0;
                    state_next = S_M_START;
                end else begin
                    state_next = S_RES;
                end
            end
            S_M_START: begin
                cnt_next   = '0;
                state_next = S_M_STEP;
            end
            S_M_STEP: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = S_M_SAVE;
            end
            S_M_SAVE: begin
                if (!hs_reg) begin
                    hs_next    = 1'b1;
                    state_next = S_M_START;
                end else begin
                    hs_next    = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                if (!hs_reg) begin
                    hs_next    = 1'b1;
                    state_next = S_RD;
                end else begin
                    state_next = S_RES;
                end
            end
            S_RES: if (!sts.out_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.hsel = hs_reg;
        cmd.idx  = k_reg;
        cmd.pos  = pos_reg;
        cmd.op   = DP_NOP;
        s_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR: cmd.op = DP_CLR;
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = DP_BYTE;
            end
            S_R_MUL: begin
                cmd.op  = DP_RND_MUL;
                cmd.pos = {k_reg[1:0], 2'b00};
            end
            S_R_ADD:   cmd.op = DP_RND_ADD;
            S_R_LANE:  cmd.op = DP_RND_LANE;
            S_F_INIT:  cmd.op = DP_FIN_INIT;
            S_F_LEN:   cmd.op = DP_FIN_LEN;
            S_W_MUL:   cmd.op = DP_W_MUL;
            S_W_ADD:   cmd.op = DP_W_ADD;
            S_W_MUL2:  cmd.op = DP_W_MUL2;
            S_B_MUL:   cmd.op = DP_B_MUL;
            S_B_ADD:   cmd.op = DP_B_ADD;
            S_B_MUL2:  cmd.op = DP_B_MUL2;
            S_X1:      cmd.op = DP_X15;
            S_X2:      cmd.op = DP_XM2;
            S_X3:      cmd.op = DP_X13;
            S_X4:      cmd.op = DP_XM3;
            S_X5:      cmd.op = DP_X16;
            S_F_SAVE:  cmd.op = DP_SAVE;
            S_M_START: cmd.op = DP_MOD_START;
            S_M_STEP:  cmd.op = DP_MOD_STEP;
            S_M_SAVE:  cmd.op = DP_MOD_SAVE;
            S_RD:      cmd.op = DP_RD;
            S_CHK:     cmd.op = DP_CHK;
            S_RES:     if (!sts.out_full) cmd.op = DP_RES;
            default:   cmd.op = DP_NOP;
        endcase
    end

    remainder_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_M_STEP && cnt_reg == 5'd31) |=> (state_reg == S_M_SAVE))
        else $error("remainder pass did not end after 32 steps");

    result_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RES && !sts.out_full) |=> (state_reg == S_IDLE))
        else $error("controller stuck after issuing result");

    intake_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_BYTE) |-> (state_reg == S_IDLE && s_valid))
        else $error("byte taken outside idle");

endmodule

`default_nettype wire

// File: sv/bfth_dp.sv
// ----------------------------------------------------------------------------
// bfth_dp
// Datapath: config registers, hash lanes, stripe buffer, shared multiplier,
// serial remainder unit, filter store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfth_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bfth_pkg::ctl_cmd_t cmd,
    output bfth_pkg::ctl_sts_t      sts,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire bfth_pkg::in_t      s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bfth_pkg::out_t          m_data
);
    import bfth_pkg::*;

    logic [31:0]   seed_one_reg, seed_two_reg;
    logic [1:0]    mode_reg;
    logic [10:0]   wcount_reg;

    logic [31:0]   lane_reg [8];
    logic [7:0]    tail_reg [16];
    logic [31:0]   len_reg;
    logic [3:0]    fill_reg;
    logic          long_reg, key_open_reg, stripe_full_reg;
    logic          cmd_reg, last_reg;
    logic [31:0]   acc_reg, prod_reg;
    logic [31:0]   hash_reg [2];
    logic [31:0]   dvd_reg;
    logic [AW-1:0] rem_reg;
    logic [AW-1:0] idx_reg [2];
    logic          hit_reg;
    logic [AW-1:0] clr_reg;
    logic          m_valid_reg;
    out_t          m_data_reg;

    logic [31:0]   le32, mul_a, mul_k, mul_res, fin_sum;
    logic [NW-1:0] n_eff;
    logic [AW:0]   n_ext, div_tmp;
    logic [AW-1:0] rem_new;
    logic [31:0]   b_src;
    logic [4:0]    bpos;
    logic [3:0]    fill_eff;
    logic [2:0]    base;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    assign le32 = {tail_reg[cmd.pos + 4'd3], tail_reg[cmd.pos + 4'd2],
                   tail_reg[cmd.pos + 4'd1], tail_reg[cmd.pos]};
    assign base = {cmd.hsel, 2'b00};
    assign fill_eff = key_open_reg ? fill_reg : 4'd0;

    // 0 acts as 1, anything past the store size as the store size
    always_comb begin
        if (wcount_reg == 11'd0)
            n_eff = NW'(1);
        else if (32'(wcount_reg) > 32'(MAX_WORDS))
            n_eff = NW'(MAX_WORDS);
        else
            n_eff = NW'(wcount_reg);
    end
    assign n_ext   = (AW+1)'(n_eff);
    assign div_tmp = {rem_reg, dvd_reg[31]};
    assign rem_new = (div_tmp >= n_ext) ? AW'(div_tmp - n_ext) : div_tmp[AW-1:0];

    // bit index: other hash mod W
    assign b_src = cmd.hsel ? hash_reg[0] : hash_reg[1];
    always_comb begin
        unique case (mode_reg)
            MODE_W8:  bpos = {2'b00, b_src[2:0]};
            MODE_W16: bpos = {1'b0, b_src[3:0]};
            MODE_W32: bpos = b_src[4:0];
            default:  bpos = 5'd0;
        endcase
    end

    assign fin_sum = rotl(lane_reg[base], 1) + rotl(lane_reg[base + 3'd1], 7)
                   + rotl(lane_reg[base + 3'd2], 12) + rotl(lane_reg[base + 3'd3], 18);

    // shared multiplier
    always_comb begin
        unique case (cmd.op)
            DP_RND_MUL:  begin mul_a = le32;                   mul_k = PR2; end
            DP_RND_LANE: begin mul_a = acc_reg;                mul_k = PR1; end
            DP_W_MUL:    begin mul_a = le32;                   mul_k = PR3; end
            DP_W_MUL2:   begin mul_a = acc_reg;                mul_k = PR4; end
            DP_B_MUL:    begin mul_a = {24'd0, tail_reg[cmd.pos]}; mul_k = PR5; end
            DP_B_MUL2:   begin mul_a = acc_reg;                mul_k = PR1; end
            DP_XM2:      begin mul_a = acc_reg;                mul_k = PR2; end
            DP_XM3:      begin mul_a = acc_reg;                mul_k = PR3; end
            default:     begin mul_a = '0;                     mul_k = '0;  end
        endcase
    end
    assign mul_res = 32'(mul_a * mul_k);

    // store port
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg[cmd.hsel];
        ram_wdata = ram_rdata | (32'd1 << bpos);
        if (cmd.op == DP_CLR) begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end else if (cmd.op == DP_CHK && cmd_reg == CMD_INSERT) begin
            ram_we = 1'b1;
        end
    end

    bfth_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_one_reg <= 32'd0;
            seed_two_reg <= 32'd1;
            mode_reg     <= MODE_W32;
            wcount_reg   <= 11'd1024;
            key_open_reg <= 1'b0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SEED_ONE:   seed_one_reg <= cfg_data;
                    CFG_SEED_TWO:   seed_two_reg <= cfg_data;
                    CFG_WORD_MODE:  mode_reg     <= cfg_data[1:0];
                    CFG_WORD_COUNT: wcount_reg   <= cfg_data[10:0];
                    default:        ;
                endcase
            end
            if (cmd.op == DP_CLR)  clr_reg <= clr_reg + AW'(1);
            if (cmd.op == DP_BYTE) key_open_reg <= 1'b1;
            if (cmd.op == DP_SAVE && cmd.hsel) key_open_reg <= 1'b0;
            if (cmd.op == DP_RES)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_BYTE: begin
                if (!key_open_reg) begin
                    lane_reg[0] <= seed_one_reg + PR1 + PR2;
                    lane_reg[1] <= seed_one_reg + PR2;
                    lane_reg[2] <= seed_one_reg;
                    lane_reg[3] <= seed_one_reg - PR1;
                    lane_reg[4] <= seed_two_reg + PR1 + PR2;
                    lane_reg[5] <= seed_two_reg + PR2;
                    lane_reg[6] <= seed_two_reg;
                    lane_reg[7] <= seed_two_reg - PR1;
                    len_reg     <= 32'd1;
                    long_reg    <= 1'b0;
                end else begin
                    len_reg  <= len_reg + 32'd1;
                    long_reg <= long_reg | (fill_eff == 4'd15);
                end
                tail_reg[fill_eff] <= s_data.key_byte;
                fill_reg           <= fill_eff + 4'd1;
                stripe_full_reg    <= (fill_eff == 4'd15);
                cmd_reg            <= s_data.cmd;
                last_reg           <= s_data.last_byte;
            end
            DP_RND_MUL, DP_W_MUL, DP_B_MUL: prod_reg <= mul_res;
            DP_RND_ADD:  acc_reg <= rotl(lane_reg[cmd.idx] + prod_reg, 13);
            DP_RND_LANE: lane_reg[cmd.idx] <= mul_res;
            DP_FIN_INIT: acc_reg <= long_reg ? fin_sum : lane_reg[base + 3'd2] + PR5;
            DP_FIN_LEN:  acc_reg <= acc_reg + len_reg;
            DP_W_ADD:    acc_reg <= rotl(acc_reg + prod_reg, 17);
            DP_B_ADD:    acc_reg <= rotl(acc_reg + prod_reg, 11);
            DP_W_MUL2, DP_B_MUL2, DP_XM2, DP_XM3: acc_reg <= mul_res;
            DP_X15:      acc_reg <= acc_reg ^ (acc_reg >> 15);
            DP_X13:      acc_reg <= acc_reg ^ (acc_reg >> 13);
            DP_X16:      acc_reg <= acc_reg ^ (acc_reg >> 16);
            DP_SAVE:     hash_reg[cmd.hsel] <= acc_reg;
            DP_MOD_START: begin
                dvd_reg <= hash_reg[cmd.hsel];
                rem_reg <= '0;
                if (!cmd.hsel) hit_reg <= 1'b1;
            end
            DP_MOD_STEP: begin
                rem_reg <= rem_new;
                dvd_reg <= {dvd_reg[30:0], 1'b0};
            end
            DP_MOD_SAVE: idx_reg[cmd.hsel] <= rem_reg;
            DP_CHK:      hit_reg <= hit_reg & ram_rdata[bpos];
            DP_RES: begin
                m_data_reg.was_query <= cmd_reg;
                if (mode_reg == MODE_INVALID)
                    m_data_reg.hit <= 1'b0;
                else if (cmd_reg == CMD_QUERY)
                    m_data_reg.hit <= hit_reg;
                else
                    m_data_reg.hit <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.clr_last    = (clr_reg == AW'(MAX_WORDS - 1));
    assign sts.stripe_full = stripe_full_reg;
    assign sts.last        = last_reg;
    assign sts.fill        = fill_reg;
    assign sts.mode_ok     = (mode_reg != MODE_INVALID);
    assign sts.out_full    = m_valid_reg;

    no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_RES) |-> !m_valid_reg)
        else $error("result register overwritten");

    rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_MOD_STEP) |=> ({1'b0, rem_reg} < n_ext))
        else $error("remainder not below word count");

    key_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_BYTE) |=> key_open_reg)
        else $error("key not open after byte");

endmodule

`default_nettype wire
